>>> src/cdq_pkg.sv
`timescale 1ns / 1ps
// Shared definitions for the circular deque: operation and status codes,
// and the default ring depth. No dependencies.
package cdq_pkg;

    // Default number of words held in the ring
    localparam int unsigned CdqDepth = 8;

    // Operation carried by an input transfer
    typedef enum logic [1:0] {
        KIND_PUSH_FRONT = 2'd0,
        KIND_PUSH_BACK  = 2'd1,
        KIND_POP_FRONT  = 2'd2,
        KIND_POP_BACK   = 2'd3
    } t_kind;

    // Outcome reported with every result
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

endpackage

>>> src/circular_deque_top.sv
`timescale 1ns / 1ps
// Circular deque top level: ring memory, pointer and count logic, result register.
// Depends on cdq_pkg for operation codes, status codes and the default depth.
//
// Double-ended queue of signed 32-bit words held in a ring of DEPTH entries in a
// synchronous memory with a registered read port. Each input transfer is one
// operation (push front, push back, pop front, pop back) and yields exactly one
// result carrying the popped word, a status (ok, full, empty) and the occupancy
// after the operation. Pushes, refused pushes and refused pops go straight to the
// result register; a successful pop passes through the S_READ state, because the
// popped word comes from the memory read port in the cycle after the address is
// issued. Only one operation is in flight at a time; a new operation is taken as
// soon as the result register is free or its result is being taken in the same
// cycle. Refused operations leave all state unchanged and return a popped word of
// zero. The occupancy output is the count truncated to four bits.
module circular_deque_top
    import cdq_pkg::*;
#(
    parameter int unsigned DEPTH = CdqDepth
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // operation channel
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_kind,
    input  logic signed [31:0] i_push_value,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_pop_value,
    output logic [1:0]         o_status,
    output logic [3:0]         o_occupancy
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LastIdx = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FullCnt = CW'(DEPTH);

    typedef enum logic {
        S_IDLE,
        S_READ
    } t_state;

    // Control and pointer state
    t_state         r_state,     n_state;
    logic [AW-1:0]  r_front,     n_front;
    logic [AW-1:0]  r_back,      n_back;
    logic [CW-1:0]  r_count,     n_count;

    // Result register
    logic           r_out_valid, n_out_valid;
    logic [31:0]    r_pop_value, n_pop_value;
    t_status        r_status,    n_status;
    logic [3:0]     r_occ,       n_occ;

    // Ring memory and its ports
    logic [31:0]    r_mem [DEPTH];
    logic [31:0]    r_rd_data;
    logic           w_we;
    logic [AW-1:0]  w_waddr;
    logic           w_re;
    logic [AW-1:0]  w_raddr;

    logic           w_accept;
    logic           w_out_take;
    logic [AW-1:0]  w_front_dec;
    logic [AW-1:0]  w_front_inc;
    logic [AW-1:0]  w_back_dec;
    logic [AW-1:0]  w_back_inc;

    assign o_in_ready  = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_out_take  = r_out_valid && i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_pop_value = r_pop_value;
    assign o_status    = r_status;
    assign o_occupancy = r_occ;

    // Wrap pointers around the ring
    assign w_front_dec = (r_front == '0)      ? LastIdx : r_front - AW'(1);
    assign w_front_inc = (r_front == LastIdx) ? '0      : r_front + AW'(1);
    assign w_back_dec  = (r_back == '0)       ? LastIdx : r_back - AW'(1);
    assign w_back_inc  = (r_back == LastIdx)  ? '0      : r_back + AW'(1);

    // Decode the operation, steer the memory ports and form the next result
    always_comb begin
        n_state     = r_state;
        n_front     = r_front;
        n_back      = r_back;
        n_count     = r_count;
        n_out_valid = w_out_take ? 1'b0 : r_out_valid;
        n_pop_value = r_pop_value;
        n_status    = r_status;
        n_occ       = r_occ;
        w_we        = 1'b0;
        w_waddr     = r_front;
        w_re        = 1'b0;
        w_raddr     = r_front;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_pop_value = '0;
                    n_status    = ST_OK;
                    unique case (t_kind'(i_kind))
                        KIND_PUSH_FRONT: begin
                            if (r_count == FullCnt) begin
                                n_status = ST_FULL;
                            end else begin
                                n_front = w_front_dec;
                                n_count = r_count + CW'(1);
                                w_we    = 1'b1;
                                w_waddr = w_front_dec;
                            end
                        end
                        KIND_PUSH_BACK: begin
                            if (r_count == FullCnt) begin
                                n_status = ST_FULL;
                            end else begin
                                n_back  = w_back_inc;
                                n_count = r_count + CW'(1);
                                w_we    = 1'b1;
                                w_waddr = w_back_inc;
                            end
                        end
                        KIND_POP_FRONT: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_front = w_front_inc;
                                n_count = r_count - CW'(1);
                                w_re    = 1'b1;
                                w_raddr = r_front;
                            end
                        end
                        KIND_POP_BACK: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_back  = w_back_dec;
                                n_count = r_count - CW'(1);
                                w_re    = 1'b1;
                                w_raddr = r_back;
                            end
                        end
                        default: begin
                            n_status = ST_OK;
                        end
                    endcase
                    n_occ = 4'(n_count);
                    // a successful pop waits in S_READ for the memory read
                    if (w_re) begin
                        n_state = S_READ;
                    end else begin
                        n_out_valid = 1'b1;
                    end
                end
            end
            S_READ: begin
                n_out_valid = 1'b1;
                n_pop_value = r_rd_data;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Ring memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= i_push_value;
        end
        if (w_re) begin
            r_rd_data <= r_mem[w_raddr];
        end
    end

    // Hold state, pointers and the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_front     <= '0;
            r_back      <= LastIdx;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_front     <= n_front;
            r_back      <= n_back;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_pop_value <= n_pop_value;
        r_status    <= n_status;
        r_occ       <= n_occ;
    end

    // Count never exceeds the ring depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FullCnt)
        else $error("deque count above depth");

    // While empty, the back pointer sits one place behind the front pointer
    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_back == w_front_dec))
        else $error("pointers inconsistent while empty");

    // A pending memory read always delivers a result in the next cycle
    a_read_delivers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |=> (o_out_valid && r_state == S_IDLE))
        else $error("pop result not delivered after read");

    // Refused and push operations report a zero popped word
    a_zero_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !w_re) |=> (o_pop_value == '0))
        else $error("non-pop result carries a word");

endmodule
